FILE: rtl/ebls_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Energy budget load shedder package
// Shared constants, types and the zone hysteresis function.
// ----------------------------------------------------------------------------
package ebls_pkg;

  localparam int unsigned ENERGY_BITS_DEF = 27;
  localparam int unsigned PCT_BITS        = 14;
  localparam int unsigned CNT_BITS        = 4;
  localparam int unsigned ZONE_BITS       = 3;
  localparam int unsigned BUDGET_RESET    = 40;
  localparam int unsigned DROP_TOL        = 5;

  localparam logic [PCT_BITS-1:0] PCT_FULL     = 14'd10000;
  localparam logic [CNT_BITS-1:0] DIV_LAST_BIT = 4'd13;

  localparam logic [PCT_BITS-1:0] PCT_4_DOWN = 14'd6700;
  localparam logic [PCT_BITS-1:0] PCT_3_UP   = 14'd7200;
  localparam logic [PCT_BITS-1:0] PCT_3_DOWN = 14'd3700;
  localparam logic [PCT_BITS-1:0] PCT_2_UP   = 14'd4200;
  localparam logic [PCT_BITS-1:0] PCT_2_DOWN = 14'd700;
  localparam logic [PCT_BITS-1:0] PCT_1_UP   = 14'd1200;
  localparam logic [PCT_BITS-1:0] PCT_CUT    = 14'd200;

  localparam logic [ZONE_BITS-1:0] ZONE_CUTOFF = 3'd0;
  localparam logic [ZONE_BITS-1:0] ZONE_G1     = 3'd1;
  localparam logic [ZONE_BITS-1:0] ZONE_G2     = 3'd2;
  localparam logic [ZONE_BITS-1:0] ZONE_G3     = 3'd3;
  localparam logic [ZONE_BITS-1:0] ZONE_ALL    = 3'd4;

  typedef enum logic [1:0] {
    KIND_SAMPLE  = 2'd0,
    KIND_STOP    = 2'd1,
    KIND_RESUME  = 2'd2,
    KIND_RESTART = 2'd3
  } kind_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CMD,
    ST_USED,
    ST_REM,
    ST_MUL,
    ST_DIV,
    ST_ZONE,
    ST_FIN
  } state_e;

  function automatic logic [ZONE_BITS-1:0] next_zone(input logic [PCT_BITS-1:0] pct,
                                                     input logic [ZONE_BITS-1:0] prev);
    logic [ZONE_BITS-1:0] z;
    z = prev;
    if (pct == '0) begin
      z = ZONE_CUTOFF;
    end else begin
      case (prev)
        ZONE_ALL: begin
          if (pct < PCT_4_DOWN) z = ZONE_G3;
        end
        ZONE_G3: begin
          if (pct >= PCT_3_UP) z = ZONE_ALL;
          else if (pct < PCT_3_DOWN) z = ZONE_G2;
        end
        ZONE_G2: begin
          if (pct >= PCT_2_UP) z = ZONE_G3;
          else if (pct < PCT_2_DOWN) z = ZONE_G1;
        end
        ZONE_G1: begin
          if (pct >= PCT_1_UP) z = ZONE_G2;
          else if (pct <= PCT_CUT) z = ZONE_CUTOFF;
        end
        ZONE_CUTOFF: begin
          if (pct > PCT_CUT) z = ZONE_G1;
        end
        default: begin
          z = prev;
        end
      endcase
    end
    return z;
  endfunction

endpackage
`default_nettype wire

FILE: rtl/energy_budget_load_shedder.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Energy budget load shedder
// Filters meter totals, tracks used and remaining energy against a budget,
// and drives four priority load groups through a five-zone hysteresis machine.
// ----------------------------------------------------------------------------
// A paused item passes through the command and finish states; a running item
// also takes the used, remaining, multiply, divide and zone states, and a zero
// budget skips multiply and divide. The 14-step restoring divider shares one
// subtractor with the used and remaining steps. One item is in work at a time;
// the output register lets the next item enter while a result waits. Reset
// leaves the controller paused with all loads on in its zone, budget 40 and
// frozen values 0, 40 and 10000.
module energy_budget_load_shedder #(
  parameter int unsigned EnergyBits = ebls_pkg::ENERGY_BITS_DEF
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  cfg_valid_i,
  output logic                       cfg_ready_o,
  input  wire logic [EnergyBits-1:0] cfg_data_i,
  input  wire logic                  in_valid_i,
  output logic                       in_ready_o,
  input  wire logic [1:0]            kind_i,
  input  wire logic [EnergyBits-1:0] meter_total_i,
  input  wire logic                  reading_valid_i,
  output logic                       out_valid_o,
  input  wire logic                  out_ready_i,
  output logic [EnergyBits-1:0]      used_energy_o,
  output logic [EnergyBits-1:0]      remaining_energy_o,
  output logic [ebls_pkg::PCT_BITS-1:0]  remaining_pct_o,
  output logic [ebls_pkg::ZONE_BITS-1:0] load_zone_o,
  output logic                       group1_on_o,
  output logic                       group2_on_o,
  output logic                       group3_on_o,
  output logic                       group4_on_o,
  output logic                       paused_flag_o
);

  localparam int unsigned PB = ebls_pkg::PCT_BITS;
  localparam int unsigned ZB = ebls_pkg::ZONE_BITS;
  localparam int unsigned CB = ebls_pkg::CNT_BITS;

  ebls_pkg::state_e state_q, state_d;

  logic [EnergyBits-1:0] budget_q;
  logic [EnergyBits-1:0] last_good_q;
  logic                  have_good_q;
  logic [EnergyBits-1:0] baseline_q;
  logic                  paused_q;
  logic                  first_pend_q;
  logic [ZB-1:0]         zone_q;
  logic [EnergyBits-1:0] frz_used_q;
  logic [EnergyBits-1:0] frz_rem_q;
  logic [PB-1:0]         frz_pct_q;
  logic                  out_valid_q;

  logic [1:0]            kind_q;
  logic [EnergyBits-1:0] meter_q;
  logic                  rvalid_q;
  logic [EnergyBits-1:0] total_q;
  logic [EnergyBits-1:0] used_q;
  logic [EnergyBits-1:0] rem_q;
  logic [EnergyBits-1:0] div_r_q;
  logic [PB-1:0]         div_lo_q;
  logic [PB-1:0]         quo_q;
  logic [CB-1:0]         cnt_q;

  logic [EnergyBits-1:0] out_used_q;
  logic [EnergyBits-1:0] out_rem_q;
  logic [PB-1:0]         out_pct_q;
  logic [ZB-1:0]         out_zone_q;
  logic                  out_paused_q;

  logic                  in_acc;
  logic                  fin_go;
  logic                  restart_cyc;
  logic                  paused_nx;
  logic                  need_filter;
  logic                  drop;
  logic                  take_new;
  logic [EnergyBits-1:0] filtered;
  logic [EnergyBits:0]   alu_a;
  logic [EnergyBits:0]   alu_b;
  logic [EnergyBits:0]   alu_diff;
  logic                  alu_borrow;
  logic [EnergyBits+PB-1:0] product;
  logic [PB-1:0]         pct_sat;
  logic [ZB-1:0]         zone_nx;

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = (state_q == ebls_pkg::ST_IDLE);
  assign in_acc      = in_valid_i && in_ready_o;
  assign fin_go      = !out_valid_q || out_ready_i;

  always_comb begin
    restart_cyc = (kind_q == ebls_pkg::KIND_RESTART)
               || ((kind_q == ebls_pkg::KIND_RESUME) && first_pend_q);
    if (kind_q == ebls_pkg::KIND_STOP) begin
      paused_nx = 1'b1;
    end else if ((kind_q == ebls_pkg::KIND_RESUME) || (kind_q == ebls_pkg::KIND_RESTART)) begin
      paused_nx = 1'b0;
    end else begin
      paused_nx = paused_q;
    end
    need_filter = restart_cyc || !paused_nx;
    drop = have_good_q
        && (({1'b0, meter_q} + (EnergyBits+1)'(ebls_pkg::DROP_TOL)) < {1'b0, last_good_q});
    take_new = rvalid_q && !drop;
    if (!rvalid_q) begin
      filtered = have_good_q ? last_good_q : '0;
    end else if (drop) begin
      filtered = last_good_q;
    end else begin
      filtered = meter_q;
    end
  end

  always_comb begin
    alu_a = {1'b0, total_q};
    alu_b = {1'b0, baseline_q};
    case (state_q)
      ebls_pkg::ST_REM: begin
        alu_a = {1'b0, budget_q};
        alu_b = {1'b0, used_q};
      end
      ebls_pkg::ST_DIV: begin
        alu_a = {div_r_q, div_lo_q[PB-1]};
        alu_b = {1'b0, budget_q};
      end
      default: begin
        alu_a = {1'b0, total_q};
        alu_b = {1'b0, baseline_q};
      end
    endcase
  end

  ebls_alu #(
    .Width (EnergyBits + 1)
  ) u_alu (
    .a_i      (alu_a),
    .b_i      (alu_b),
    .diff_o   (alu_diff),
    .borrow_o (alu_borrow)
  );

  assign product = {{PB{1'b0}}, rem_q} * (EnergyBits+PB)'(ebls_pkg::PCT_FULL);
  assign pct_sat = (quo_q > ebls_pkg::PCT_FULL) ? ebls_pkg::PCT_FULL : quo_q;
  assign zone_nx = ebls_pkg::next_zone(pct_sat, zone_q);

  always_comb begin
    state_d = state_q;
    case (state_q)
      ebls_pkg::ST_IDLE: begin
        if (in_acc) state_d = ebls_pkg::ST_CMD;
      end
      ebls_pkg::ST_CMD: begin
        state_d = paused_nx ? ebls_pkg::ST_FIN : ebls_pkg::ST_USED;
      end
      ebls_pkg::ST_USED: begin
        state_d = ebls_pkg::ST_REM;
      end
      ebls_pkg::ST_REM: begin
        state_d = (budget_q == '0) ? ebls_pkg::ST_ZONE : ebls_pkg::ST_MUL;
      end
      ebls_pkg::ST_MUL: begin
        state_d = ebls_pkg::ST_DIV;
      end
      ebls_pkg::ST_DIV: begin
        if (cnt_q == '0) state_d = ebls_pkg::ST_ZONE;
      end
      ebls_pkg::ST_ZONE: begin
        state_d = ebls_pkg::ST_FIN;
      end
      ebls_pkg::ST_FIN: begin
        if (fin_go) state_d = ebls_pkg::ST_IDLE;
      end
      default: begin
        state_d = ebls_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ebls_pkg::ST_IDLE;
      budget_q     <= EnergyBits'(ebls_pkg::BUDGET_RESET);
      last_good_q  <= '0;
      have_good_q  <= 1'b0;
      baseline_q   <= '0;
      paused_q     <= 1'b1;
      first_pend_q <= 1'b1;
      zone_q       <= ebls_pkg::ZONE_ALL;
      frz_used_q   <= '0;
      frz_rem_q    <= EnergyBits'(ebls_pkg::BUDGET_RESET);
      frz_pct_q    <= ebls_pkg::PCT_FULL;
      out_valid_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_valid_i) begin
        budget_q <= cfg_data_i;
      end
      if ((state_q == ebls_pkg::ST_FIN) && fin_go) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ebls_pkg::ST_CMD: begin
          paused_q <= paused_nx;
          if (need_filter && take_new) begin
            last_good_q <= meter_q;
            have_good_q <= 1'b1;
          end
          if (restart_cyc) begin
            baseline_q   <= filtered;
            first_pend_q <= 1'b0;
          end
        end
        ebls_pkg::ST_ZONE: begin
          frz_used_q <= used_q;
          frz_rem_q  <= rem_q;
          frz_pct_q  <= pct_sat;
          zone_q     <= zone_nx;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      kind_q   <= kind_i;
      meter_q  <= meter_total_i;
      rvalid_q <= reading_valid_i;
    end
    case (state_q)
      ebls_pkg::ST_CMD: begin
        total_q <= filtered;
      end
      ebls_pkg::ST_USED: begin
        used_q <= alu_borrow ? '0 : alu_diff[EnergyBits-1:0];
      end
      ebls_pkg::ST_REM: begin
        rem_q <= alu_borrow ? '0 : alu_diff[EnergyBits-1:0];
        quo_q <= '0;
      end
      ebls_pkg::ST_MUL: begin
        div_r_q  <= product[EnergyBits+PB-1:PB];
        div_lo_q <= product[PB-1:0];
        cnt_q    <= ebls_pkg::DIV_LAST_BIT;
        quo_q    <= '0;
      end
      ebls_pkg::ST_DIV: begin
        if (!alu_borrow) begin
          div_r_q <= alu_diff[EnergyBits-1:0];
        end else begin
          div_r_q <= alu_a[EnergyBits-1:0];
        end
        div_lo_q <= {div_lo_q[PB-2:0], 1'b0};
        quo_q    <= {quo_q[PB-2:0], !alu_borrow};
        cnt_q    <= cnt_q - CB'(1);
      end
      ebls_pkg::ST_FIN: begin
        if (fin_go) begin
          out_used_q   <= frz_used_q;
          out_rem_q    <= frz_rem_q;
          out_pct_q    <= frz_pct_q;
          out_zone_q   <= zone_q;
          out_paused_q <= paused_q;
        end
      end
      default: begin
      end
    endcase
  end

  assign out_valid_o        = out_valid_q;
  assign used_energy_o      = out_used_q;
  assign remaining_energy_o = out_rem_q;
  assign remaining_pct_o    = out_pct_q;
  assign load_zone_o        = out_zone_q;
  assign paused_flag_o      = out_paused_q;
  assign group1_on_o = !out_paused_q && (out_zone_q >= ebls_pkg::ZONE_G1)
                    && (out_zone_q <= ebls_pkg::ZONE_ALL);
  assign group2_on_o = !out_paused_q && (out_zone_q >= ebls_pkg::ZONE_G2)
                    && (out_zone_q <= ebls_pkg::ZONE_ALL);
  assign group3_on_o = !out_paused_q && (out_zone_q >= ebls_pkg::ZONE_G3)
                    && (out_zone_q <= ebls_pkg::ZONE_ALL);
  assign group4_on_o = !out_paused_q && (out_zone_q == ebls_pkg::ZONE_ALL);

endmodule
`default_nettype wire

FILE: rtl/ebls_alu.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Energy budget load shedder shared subtractor
// One subtract and compare unit, shared by the used, remaining and divide steps.
// ----------------------------------------------------------------------------
module ebls_alu #(
  parameter int unsigned Width = ebls_pkg::ENERGY_BITS_DEF + 1
) (
  input  wire logic [Width-1:0] a_i,
  input  wire logic [Width-1:0] b_i,
  output logic      [Width-1:0] diff_o,
  output logic                  borrow_o
);

  logic [Width:0] full;

  assign full     = {1'b0, a_i} - {1'b0, b_i};
  assign diff_o   = full[Width-1:0];
  assign borrow_o = full[Width];

endmodule
`default_nettype wire
